>>> hw/rtl/vgsd_pkg.sv
// ----------------------------------------------------------------------------
// vgsd_pkg
// Shared constants, register map and types of the voxel grid dilation core.
// ----------------------------------------------------------------------------
`default_nettype none

package vgsd_pkg;

  // Grid bounds
  localparam int MAX_X      = 32;
  localparam int MAX_Y      = 32;
  localparam int MAX_Z      = 32;
  localparam int MAX_RADIUS = 4;

  localparam int XW      = 5;            // coordinate field widths
  localparam int YW      = 5;
  localparam int ZW      = 5;
  localparam int ROW_AW  = XW + YW;      // one memory row per (x,y) column
  localparam int NDZ     = 2 * MAX_RADIUS + 1;
  localparam int SIZE_W  = 6;
  localparam int RAD_W   = 3;
  localparam int LIM_W   = 6;
  localparam int OFF_W   = 4;            // signed neighbor offset
  localparam int ROWS    = 1 << ROW_AW;

  // Register file
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam logic [2:0] REG_GRID_X = 3'd0;
  localparam logic [2:0] REG_GRID_Y = 3'd1;
  localparam logic [2:0] REG_GRID_Z = 3'd2;
  localparam logic [2:0] REG_RADIUS = 3'd3;
  localparam logic [2:0] REG_LIMIT  = 3'd4;

  localparam logic [SIZE_W-1:0] RST_GRID   = 6'd32;
  localparam logic [RAD_W-1:0]  RST_RADIUS = 3'd1;
  localparam logic [LIM_W-1:0]  RST_LIMIT  = 6'd1;

  // Item modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Effective (saturated) configuration
  typedef struct packed {
    logic [SIZE_W-1:0] sx;
    logic [SIZE_W-1:0] sy;
    logic [SIZE_W-1:0] sz;
    logic [RAD_W-1:0]  rad;
    logic [LIM_W-1:0]  lim;
  } cfg_eff_t;

  // Memory access request
  typedef struct packed {
    logic              we;
    logic [ROW_AW-1:0] waddr;
    logic [MAX_Z-1:0]  wdata;
    logic              re;
    logic [ROW_AW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

>>> hw/rtl/vgsd_cfg.sv
// ----------------------------------------------------------------------------
// vgsd_cfg
// APB register file; saturates grid sizes and radius for the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module vgsd_cfg
  import vgsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_eff_t               cfg
);

  logic [SIZE_W-1:0] gx_r, gy_r, gz_r;
  logic [RAD_W-1:0]  rad_r;
  logic [LIM_W-1:0]  lim_r;
  logic [2:0]        idx;
  logic              wr;

  assign idx    = paddr[4:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gx_r  <= RST_GRID;
      gy_r  <= RST_GRID;
      gz_r  <= RST_GRID;
      rad_r <= RST_RADIUS;
      lim_r <= RST_LIMIT;
    end else if (wr) begin
      case (idx)
        REG_GRID_X: gx_r  <= pwdata[SIZE_W-1:0];
        REG_GRID_Y: gy_r  <= pwdata[SIZE_W-1:0];
        REG_GRID_Z: gz_r  <= pwdata[SIZE_W-1:0];
        REG_RADIUS: rad_r <= pwdata[RAD_W-1:0];
        REG_LIMIT:  lim_r <= pwdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_GRID_X: prdata = {{(APB_DW-SIZE_W){1'b0}}, gx_r};
      REG_GRID_Y: prdata = {{(APB_DW-SIZE_W){1'b0}}, gy_r};
      REG_GRID_Z: prdata = {{(APB_DW-SIZE_W){1'b0}}, gz_r};
      REG_RADIUS: prdata = {{(APB_DW-RAD_W){1'b0}}, rad_r};
      REG_LIMIT:  prdata = {{(APB_DW-LIM_W){1'b0}}, lim_r};
      default:    prdata = '0;
    endcase
  end

  // Saturate to the grid bounds
  always_comb begin
    cfg.sx  = (gx_r > SIZE_W'(MAX_X)) ? SIZE_W'(MAX_X) : gx_r;
    cfg.sy  = (gy_r > SIZE_W'(MAX_Y)) ? SIZE_W'(MAX_Y) : gy_r;
    cfg.sz  = (gz_r > SIZE_W'(MAX_Z)) ? SIZE_W'(MAX_Z) : gz_r;
    cfg.rad = (rad_r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : rad_r;
    cfg.lim = lim_r;
  end

endmodule

`default_nettype wire

>>> hw/rtl/vgsd_ram.sv
// ----------------------------------------------------------------------------
// vgsd_ram
// Occupancy memory: one row of MAX_Z bits per (x,y) column, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module vgsd_ram
  import vgsd_pkg::*;
(
  input  wire logic             clk,
  input  wire mem_req_t         req,
  output logic      [MAX_Z-1:0] rdata
);

  logic [MAX_Z-1:0] mem [ROWS];
  logic [MAX_Z-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/vgsd_ctrl.sv
// ----------------------------------------------------------------------------
// vgsd_ctrl
// Sequencer: clearing pass, load read-modify-write, neighborhood row scan.
// ----------------------------------------------------------------------------
`default_nettype none

module vgsd_ctrl
  import vgsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cfg_eff_t         cfg,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic             in_mode,
  input  wire logic [XW-1:0]    in_coord_x,
  input  wire logic [YW-1:0]    in_coord_y,
  input  wire logic [ZW-1:0]    in_coord_z,
  input  wire logic             in_occupied_in,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_inflated,
  output logic                  out_was_occupied,
  output logic                  out_out_of_range,
  output mem_req_t              mem_req,
  input  wire logic [MAX_Z-1:0] mem_rdata
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LDWR  = 3'd2;
  localparam logic [2:0] S_SELF  = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DRAIN = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  function automatic logic [2:0] mag(input logic [OFF_W-1:0] v);
    logic [OFF_W-1:0] n;
    n = '0 - v;
    return v[OFF_W-1] ? n[2:0] : v[2:0];
  endfunction

  function automatic logic [5:0] sq3(input logic [2:0] m);
    return {3'b000, m} * {3'b000, m};
  endfunction

  // Any set bit of one row within the z window and the distance limit
  function automatic logic row_hit(input logic [MAX_Z-1:0] data, input logic [ZW-1:0] z,
                                   input logic [5:0] dxy2, input cfg_eff_t c);
    logic       h;
    logic [6:0] nz;
    logic [2:0] m;
    logic [6:0] d2;
    h = 1'b0;
    for (int k = 0; k < NDZ; k++) begin
      nz = {2'b00, z} + 7'(k) - 7'(MAX_RADIUS);
      m  = (k < MAX_RADIUS) ? 3'(MAX_RADIUS - k) : 3'(k - MAX_RADIUS);
      d2 = {1'b0, dxy2} + {1'b0, sq3(m)};
      if (m <= c.rad && !nz[6] && nz[5:0] < c.sz && data[nz[4:0]] && d2 <= {1'b0, c.lim})
        h = 1'b1;
    end
    return h;
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [ROW_AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [XW-1:0]     x_r, x_nxt;
  logic [YW-1:0]     y_r, y_nxt;
  logic [ZW-1:0]     z_r, z_nxt;
  logic              occ_r, occ_nxt;
  logic [OFF_W-1:0]  dx_r, dx_nxt, dy_r, dy_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_ok_r, pend_ok_nxt;
  logic [5:0]        pend_d2_r, pend_d2_nxt;
  logic              res_hit_r, res_hit_nxt;
  logic              res_self_r, res_self_nxt;
  logic              res_oor_r, res_oor_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_hit_r, out_hit_nxt;
  logic              out_self_r, out_self_nxt;
  logic              out_oor_r, out_oor_nxt;

  logic              in_inside;
  logic              accept;
  logic [6:0]        nx, ny;
  logic              nb_ok;
  logic [OFF_W-1:0]  rad_s, rad_neg;
  logic              pend_hit;
  logic              out_free;
  logic [MAX_Z-1:0]  ld_row;

  assign in_inside = ({1'b0, in_coord_x} < cfg.sx) && ({1'b0, in_coord_y} < cfg.sy) &&
                     ({1'b0, in_coord_z} < cfg.sz);
  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign rad_s     = {1'b0, cfg.rad};
  assign rad_neg   = '0 - rad_s;
  assign nx        = {2'b00, x_r} + {{(7-OFF_W){dx_r[OFF_W-1]}}, dx_r};
  assign ny        = {2'b00, y_r} + {{(7-OFF_W){dy_r[OFF_W-1]}}, dy_r};
  assign nb_ok     = !nx[6] && (nx[5:0] < cfg.sx) && !ny[6] && (ny[5:0] < cfg.sy);
  assign pend_hit  = pend_r && pend_ok_r && row_hit(mem_rdata, z_r, pend_d2_r, cfg);
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    ld_row       = mem_rdata;
    ld_row[z_r]  = occ_r;
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    occ_nxt       = occ_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    pend_nxt      = 1'b0;
    pend_ok_nxt   = pend_ok_r;
    pend_d2_nxt   = pend_d2_r;
    res_hit_nxt   = res_hit_r;
    res_self_nxt  = res_self_r;
    res_oor_nxt   = res_oor_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = out_hit_r;
    out_self_nxt  = out_self_r;
    out_oor_nxt   = out_oor_r;
    mem_req       = '0;

    case (state_r)
      S_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_cnt_r;
        mem_req.wdata = '0;
        clr_cnt_nxt   = clr_cnt_r + 1'b1;
        if (clr_cnt_r == '1) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          x_nxt         = in_coord_x;
          y_nxt         = in_coord_y;
          z_nxt         = in_coord_z;
          occ_nxt       = in_occupied_in;
          mem_req.re    = 1'b1;
          mem_req.raddr = {in_coord_x, in_coord_y};
          if (in_mode == MODE_LOAD) begin
            if (in_inside) state_nxt = S_LDWR;
          end else if (in_inside) begin
            state_nxt = S_SELF;
          end else begin
            res_hit_nxt  = 1'b0;
            res_self_nxt = 1'b0;
            res_oor_nxt  = 1'b1;
            state_nxt    = S_DONE;
          end
        end
      end
      S_LDWR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = {x_r, y_r};
        mem_req.wdata = ld_row;
        state_nxt     = S_IDLE;
      end
      S_SELF: begin
        res_oor_nxt  = 1'b0;
        res_self_nxt = mem_rdata[z_r];
        res_hit_nxt  = mem_rdata[z_r];
        dx_nxt       = rad_neg;
        dy_nxt       = rad_neg;
        state_nxt    = mem_rdata[z_r] ? S_DONE : S_SCAN;
      end
      S_SCAN: begin
        if (pend_hit) begin
          res_hit_nxt = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          // Issue the next neighbor row; its verdict is checked in the following cycle
          mem_req.re    = 1'b1;
          mem_req.raddr = {nx[XW-1:0], ny[YW-1:0]};
          pend_nxt      = 1'b1;
          pend_ok_nxt   = nb_ok;
          pend_d2_nxt   = sq3(mag(dx_r)) + sq3(mag(dy_r));
          if (dy_r == rad_s) begin
            dy_nxt = rad_neg;
            dx_nxt = dx_r + 1'b1;
            if (dx_r == rad_s) state_nxt = S_DRAIN;
          end else begin
            dy_nxt = dy_r + 1'b1;
          end
        end
      end
      S_DRAIN: begin
        res_hit_nxt = pend_hit;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_self_nxt  = res_self_r;
          out_oor_nxt   = res_oor_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    occ_r      <= occ_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    pend_ok_r  <= pend_ok_nxt;
    pend_d2_r  <= pend_d2_nxt;
    res_hit_r  <= res_hit_nxt;
    res_self_r <= res_self_nxt;
    res_oor_r  <= res_oor_nxt;
    out_hit_r  <= out_hit_nxt;
    out_self_r <= out_self_nxt;
    out_oor_r  <= out_oor_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_inflated     = out_hit_r;
  assign out_was_occupied = out_self_r;
  assign out_out_of_range = out_oor_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result beat raised outside the completion state");

  a_no_write_in_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SELF || state_r == S_SCAN || state_r == S_DRAIN) |-> !mem_req.we)
    else $error("memory written during a query");

  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_oor_r) |-> (!out_hit_r && !out_self_r))
    else $error("out-of-range result carries occupancy");

  a_self_implies_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_self_r) |-> out_hit_r)
    else $error("occupied voxel reported as not inflated");

endmodule

`default_nettype wire

>>> hw/rtl/voxel_grid_spherical_dilation_core.sv
// ----------------------------------------------------------------------------
// voxel_grid_spherical_dilation_core
// 3D occupancy grid with spherical obstacle inflation queries.
// ----------------------------------------------------------------------------
//  Port group  Handshake              Beat contents
//  in_*        in_valid / in_stall    mode, coord_x/y/z, occupied_in
//  out_*       out_valid / out_stall  inflated, was_occupied, out_of_range
//  cfg_*       APB write/read         grid sizes, search radius, dist limit
//
//  Reset runs a clearing pass over every row (one 32-voxel z row per cycle);
//  in_stall stays high until it ends, while APB writes are taken throughout.
//  A load reads its row, then writes back the modified row; one that falls
//  outside the grid writes nothing. A query out of range goes straight to
//  its result, one on a set voxel ends after the self check, else it scans
//  up to (2r+1)^2 neighbor rows, one row read per cycle from the occupancy
//  memory; a hit ends the scan early. One item is in work at a time; a
//  finished result waits in the output register while the next item is
//  taken, and a second one holds the input stalled until out_stall drops.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_grid_spherical_dilation_core
  import vgsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // item input
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_mode,
  input  wire logic [XW-1:0]     in_coord_x,
  input  wire logic [YW-1:0]     in_coord_y,
  input  wire logic [ZW-1:0]     in_coord_z,
  input  wire logic              in_occupied_in,
  // result output
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_inflated,
  output logic                   out_was_occupied,
  output logic                   out_out_of_range,
  // configuration
  input  wire logic              cfg_psel,
  input  wire logic              cfg_penable,
  input  wire logic              cfg_pwrite,
  input  wire logic [APB_AW-1:0] cfg_paddr,
  input  wire logic [APB_DW-1:0] cfg_pwdata,
  output logic      [APB_DW-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  cfg_eff_t         cfg;
  mem_req_t         mem_req;
  logic [MAX_Z-1:0] mem_rdata;

  // Register file; hands saturated settings to the sequencer
  vgsd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  // Occupancy store: row address {x,y}, each row holds all z voxels
  vgsd_ram u_ram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Sequencer: clear, load read-modify-write, query scan of neighbor rows
  vgsd_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_occupied_in   (in_occupied_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_inflated     (out_inflated),
    .out_was_occupied (out_was_occupied),
    .out_out_of_range (out_out_of_range),
    .mem_req          (mem_req),
    .mem_rdata        (mem_rdata)
  );

endmodule

`default_nettype wire

>>> test/tb_voxel_grid_spherical_dilation_core.sv
// ----------------------------------------------------------------------------
// tb_voxel_grid_spherical_dilation_core
// Self-checking bench for the voxel grid dilation core: loads voxels, runs
// inflation queries under many grid, radius and distance settings, and checks
// every result beat against an in-bench occupancy grid and dilation predictor.
// ----------------------------------------------------------------------------
module tb_voxel_grid_spherical_dilation_core;
  import vgsd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Worst honest run: ~850 items, each with a full query scan, a sender gap
  // and a receiver stall, plus the clearing pass, the drain pauses and the
  // long hold. Take that several times over.
  localparam int CYCLE_LIMIT   = 500000;
  localparam int DRAIN_CYCLES  = 100;   // longer than the slowest query scan
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int PHASES        = 8;
  localparam int PHASE_BEATS   = 95;
  localparam int REPORT_LIMIT  = 10;

  // Register index with nothing behind it
  localparam logic [2:0] REG_SPARE = 3'd7;

  typedef struct packed {
    logic inflated;
    logic was_occupied;
    logic out_of_range;
  } dilation_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT signals
  // --------------------------------------------------------------------------
  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              in_mode = MODE_LOAD;
  logic [XW-1:0]     in_coord_x = '0;
  logic [YW-1:0]     in_coord_y = '0;
  logic [ZW-1:0]     in_coord_z = '0;
  logic              in_occupied_in = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_inflated;
  logic              out_was_occupied;
  logic              out_out_of_range;
  logic              cfg_psel = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite = 1'b0;
  logic [APB_AW-1:0] cfg_paddr = '0;
  logic [APB_DW-1:0] cfg_pwdata = '0;
  logic [APB_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  always #5 clk = ~clk;

  voxel_grid_spherical_dilation_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_mode          (in_mode),
    .in_coord_x       (in_coord_x),
    .in_coord_y       (in_coord_y),
    .in_coord_z       (in_coord_z),
    .in_occupied_in   (in_occupied_in),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_inflated     (out_inflated),
    .out_was_occupied (out_was_occupied),
    .out_out_of_range (out_out_of_range),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Predictor state: shadow occupancy grid and shadow registers
  // --------------------------------------------------------------------------
  bit                occ_grid [MAX_X][MAX_Y][MAX_Z];
  logic [SIZE_W-1:0] size_x = RST_GRID;
  logic [SIZE_W-1:0] size_y = RST_GRID;
  logic [SIZE_W-1:0] size_z = RST_GRID;
  logic [RAD_W-1:0]  radius = RST_RADIUS;
  logic [LIM_W-1:0]  dist_limit = RST_LIMIT;

  dilation_result_t  expected_results[$];

  int  error_count = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;       // random idling on both sides
  bit  hold_pending = 1'b0;  // ask the receiver for one long hold-off

  // Clamp a size register to the grid bound it can address
  function automatic int eff_dim(input logic [SIZE_W-1:0] s, input int bound);
    return (s > bound) ? bound : int'(s);
  endfunction

  function automatic bit in_grid(input int x, input int y, input int z);
    return x < eff_dim(size_x, MAX_X) && y < eff_dim(size_y, MAX_Y) &&
           z < eff_dim(size_z, MAX_Z);
  endfunction

  // Inflated occupancy of one voxel: itself, or any set voxel inside the
  // radius cube whose squared distance is within the limit. Off-grid
  // neighbors do not count.
  function automatic dilation_result_t predict_query(input int x, input int y, input int z);
    dilation_result_t res;
    int sx, sy, sz, rad, nx, ny, nz;
    sx  = eff_dim(size_x, MAX_X);
    sy  = eff_dim(size_y, MAX_Y);
    sz  = eff_dim(size_z, MAX_Z);
    rad = (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
    res = '0;
    if (!in_grid(x, y, z)) begin
      res.out_of_range = 1'b1;
      return res;
    end
    res.was_occupied = occ_grid[x][y][z];
    res.inflated     = res.was_occupied;
    for (int dx = -rad; dx <= rad; dx++) begin
      for (int dy = -rad; dy <= rad; dy++) begin
        for (int dz = -rad; dz <= rad; dz++) begin
          nx = x + dx;
          ny = y + dy;
          nz = z + dz;
          if (nx < 0 || ny < 0 || nz < 0 || nx >= sx || ny >= sy || nz >= sz) continue;
          if (occ_grid[nx][ny][nz] && (dx*dx + dy*dy + dz*dz) <= int'(dist_limit))
            res.inflated = 1'b1;
        end
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender: one input beat, held until taken. Valid stays high between
  // back-to-back beats; only a gap or a drain lowers it.
  // --------------------------------------------------------------------------
  task automatic send_beat(input logic mode, input int x, input int y, input int z,
                           input logic occ);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_coord_x     <= x[XW-1:0];
    in_coord_y     <= y[YW-1:0];
    in_coord_z     <= z[ZW-1:0];
    in_occupied_in <= occ;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // beat taken at this edge: advance the predictor
    if (mode == MODE_LOAD) begin
      if (in_grid(x, y, z)) occ_grid[x][y][z] = occ;
    end else begin
      expected_results.push_back(predict_query(x, y, z));
    end
  endtask

  task automatic query(input int x, input int y, input int z);
    send_beat(MODE_QUERY, x, y, z, 1'($urandom_range(0, 1)));
  endtask

  task automatic load(input int x, input int y, input int z, input logic occ);
    send_beat(MODE_LOAD, x, y, z, occ);
  endtask

  // Drop valid, wait for every expected result, then let a trailing load or
  // scan finish so the core is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the
  // access edge (pready is tied high).
  task automatic cfg_write(input logic [2:0] idx, input logic [APB_DW-1:0] value);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    case (idx)
      REG_GRID_X: size_x     = value[SIZE_W-1:0];
      REG_GRID_Y: size_y     = value[SIZE_W-1:0];
      REG_GRID_Z: size_z     = value[SIZE_W-1:0];
      REG_RADIUS: radius     = value[RAD_W-1:0];
      REG_LIMIT:  dist_limit = value[LIM_W-1:0];
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, quiet stretches, and one long hold-off
  // counted here when the test asks for it.
  // --------------------------------------------------------------------------
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: each taken beat against the oldest expectation
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    dilation_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_inflated, out_was_occupied, out_out_of_range};
      if (expected_results.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_LIMIT)
          $display("%0t: result beat with nothing expected: inflated=%0b was_occupied=%0b oor=%0b",
                   $realtime, got.inflated, got.was_occupied, got.out_of_range);
      end else begin
        want = expected_results.pop_front();
        if (got.inflated !== want.inflated || got.was_occupied !== want.was_occupied ||
            got.out_of_range !== want.out_of_range) begin
          error_count++;
          if (error_count <= REPORT_LIMIT)
            $display("%0t: mismatch exp inflated=%0b was_occupied=%0b oor=%0b, got %0b %0b %0b",
                     $realtime, want.inflated, want.was_occupied, want.out_of_range,
                     got.inflated, got.was_occupied, got.out_of_range);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset settings (full grid, radius 1, limit 1): face neighbors inflate,
  // edge neighbors do not; clearing a voxel frees it again.
  task automatic test_reset_settings();
    query(0, 0, 0);
    load(0, 0, 0, 1'b1);
    query(0, 0, 0);
    query(1, 0, 0);
    query(1, 1, 0);
    load(31, 31, 31, 1'b1);
    query(30, 31, 31);
    load(0, 0, 0, 1'b0);
    query(0, 0, 0);
  endtask

  // Zero limit keeps only the voxel itself; an oversize radius clamps to the
  // maximum; a write to an unmapped register changes nothing.
  task automatic test_radius_and_limit();
    settle();
    cfg_write(REG_LIMIT, 0);
    query(30, 31, 31);
    query(31, 31, 31);
    settle();
    cfg_write(REG_RADIUS, 7);
    cfg_write(REG_LIMIT, 63);
    query(27, 31, 31);
    query(26, 31, 31);
    query(27, 27, 27);
    settle();
    cfg_write(REG_SPARE, '1);
    query(27, 27, 27);
  endtask

  // Empty grid, oversize grid, and a tiny grid with loads and queries past
  // its edges.
  task automatic test_grid_bounds();
    settle();
    cfg_write(REG_GRID_X, 0);
    load(0, 0, 0, 1'b1);
    query(0, 0, 0);
    settle();
    cfg_write(REG_GRID_X, 63);
    cfg_write(REG_GRID_Y, 63);
    cfg_write(REG_GRID_Z, 63);
    query(31, 31, 31);
    query(0, 0, 0);
    settle();
    cfg_write(REG_GRID_X, 3);
    cfg_write(REG_GRID_Y, 2);
    cfg_write(REG_GRID_Z, 1);
    cfg_write(REG_RADIUS, 1);
    cfg_write(REG_LIMIT, 3);
    load(5, 0, 0, 1'b1);
    load(2, 1, 0, 1'b1);
    query(3, 0, 0);
    query(1, 0, 0);
    query(0, 1, 0);
    query(2, 1, 1);
  endtask

  // Hold the result side off for a long stretch while queries keep coming,
  // so the core backs up and stalls its input.
  task automatic test_output_backpressure();
    settle();
    cfg_write(REG_GRID_X, 32);
    cfg_write(REG_GRID_Y, 32);
    cfg_write(REG_GRID_Z, 32);
    cfg_write(REG_RADIUS, 4);
    cfg_write(REG_LIMIT, 48);
    idle_on = 1'b0;
    hold_pending = 1'b1;
    for (int i = 0; i < 12; i++)
      query($urandom_range(24, 31), $urandom_range(24, 31), $urandom_range(24, 31));
    settle();
    idle_on = 1'b1;
  endtask

  // Step a coordinate by up to span voxels, kept to the 5 bit field
  function automatic int near(input int c, input int span);
    int v;
    v = c + $urandom_range(0, 2 * span) - span;
    return (v < 0) ? 0 : (v > 31) ? 31 : v;
  endfunction

  function automatic logic [APB_DW-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return $urandom_range(33, 63);
      1:       return 1;
      2:       return 32;
      default: return $urandom_range(2, 32);
    endcase
  endfunction

  // Random phases: mostly clusters (a few loads around a center, then
  // queries around it within reach of the radius), the rest random noise.
  task automatic test_random_phases();
    int sent, cx, cy, cz, span, n;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      cfg_write(REG_GRID_X, pick_size());
      cfg_write(REG_GRID_Y, pick_size());
      cfg_write(REG_GRID_Z, pick_size());
      cfg_write(REG_RADIUS, $urandom_range(0, 7));
      cfg_write(REG_LIMIT, $urandom_range(0, 63));
      // last phase runs flat out on both sides
      idle_on = (p < PHASES - 1) ? ($urandom_range(0, 3) != 0) : 1'b0;
      span = ((radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius)) + 1;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        if ($urandom_range(0, 4) == 0) begin
          send_beat(($urandom_range(0, 1) != 0) ? MODE_QUERY : MODE_LOAD,
                    $urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 31),
                    1'($urandom_range(0, 1)));
          sent++;
        end else begin
          cx = $urandom_range(0, eff_dim(size_x, MAX_X) - 1);
          cy = $urandom_range(0, eff_dim(size_y, MAX_Y) - 1);
          cz = $urandom_range(0, eff_dim(size_z, MAX_Z) - 1);
          n  = $urandom_range(1, 3);
          for (int i = 0; i < n; i++)
            load(near(cx, span), near(cy, span), near(cz, span), $urandom_range(0, 3) != 0);
          sent += n;
          n = $urandom_range(2, 5);
          for (int i = 0; i < n; i++)
            query(near(cx, span), near(cy, span), near(cz, span));
          sent += n;
        end
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_settings();
    test_radius_and_limit();
    test_grid_bounds();
    test_output_backpressure();
    test_random_phases();
    settle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/vgsd_pkg.sv
hw/rtl/vgsd_cfg.sv
hw/rtl/vgsd_ram.sv
hw/rtl/vgsd_ctrl.sv
hw/rtl/voxel_grid_spherical_dilation_core.sv
test/tb_voxel_grid_spherical_dilation_core.sv
